// ----- rtl/core/fpwc_pkg.sv -----
`default_nettype none

package fpwc_pkg;

    localparam int FIELD_ADDR_BITS   = 24;
    localparam int INDEX_BITS        = 21;
    localparam int BYTE_BITS         = 8;
    localparam int PHRASE_BYTES      = 8;
    localparam int OFFSET_BITS       = $clog2(PHRASE_BYTES);
    localparam int PHRASE_BITS       = PHRASE_BYTES * BYTE_BITS;
    localparam int ADDR_BITS_DEFAULT = 24;

    localparam logic [BYTE_BITS-1:0]   BLANK_BYTE   = 8'hFF;
    localparam logic [PHRASE_BITS-1:0] BLANK_PHRASE = {PHRASE_BYTES{BLANK_BYTE}};
    localparam logic [OFFSET_BITS-1:0] LAST_OFFSET  = OFFSET_BITS'(PHRASE_BYTES - 1);

    localparam logic ACT_DATA  = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    typedef struct packed {
        logic                       action;
        logic [FIELD_ADDR_BITS-1:0] byte_address;
        logic [BYTE_BITS-1:0]       data_byte;
    } fpwc_in_t;

    typedef struct packed {
        logic [INDEX_BITS-1:0]  phrase_index;
        logic [PHRASE_BITS-1:0] phrase_data;
        logic                   from_flush;
    } fpwc_out_t;

    typedef struct packed {
        logic     valid;
        fpwc_in_t beat;
    } fpwc_hold_t;

endpackage

`default_nettype wire

// ----- rtl/core/flash_phrase_write_combiner.sv -----
// Gathers single programming bytes into 8-byte flash phrases.
// The item channel (item_valid, item_stall, item) carries one beat per data byte
// or flush. A byte continuing the previous address goes into the open phrase;
// any other byte drops the open phrase and starts a new one at its address
// aligned down to 8, with lower bytes at 0xFF. The phrase channel (phrase_valid,
// phrase_stall, phrase) carries one beat per completed phrase: when its eighth
// byte arrives, or on a flush of an open phrase, padding the rest with 0xFF.
// A beat goes into an input register, is combined by the phrase logic, and any
// result lands in the output register, so a phrase beat passes both registers after
// its item is accepted. One item is taken every cycle unless an emitting item waits.
// While phrase_stall holds a waiting phrase, items that emit nothing still pass;
// an item that would emit waits, and item_stall rises once the input register
// is occupied by it.
// Reset empties both registers and closes any open phrase.
`default_nettype none

module flash_phrase_write_combiner #(
    parameter int ADDR_BITS = fpwc_pkg::ADDR_BITS_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire fpwc_pkg::fpwc_in_t item,
    output logic                    phrase_valid,
    input  wire logic               phrase_stall,
    output fpwc_pkg::fpwc_out_t     phrase
);
    import fpwc_pkg::*;

    fpwc_hold_t hold;
    logic       take;

    fpwc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .take       (take),
        .hold       (hold)
    );

    fpwc_core #(
        .ADDR_BITS (ADDR_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .hold         (hold),
        .take         (take),
        .phrase_valid (phrase_valid),
        .phrase_stall (phrase_stall),
        .phrase       (phrase)
    );

endmodule

`default_nettype wire

// ----- rtl/core/fpwc_in_stage.sv -----
`default_nettype none

module fpwc_in_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire fpwc_pkg::fpwc_in_t item,
    input  wire logic              take,
    output fpwc_pkg::fpwc_hold_t   hold
);
    import fpwc_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    fpwc_in_t beat_reg;

    assign item_stall = valid_reg & ~take;

    always_comb
    begin
        valid_next = valid_reg;
        if (!valid_reg || take)
        begin
            valid_next = item_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            beat_reg <= item;
        end
    end

    assign hold.valid = valid_reg;
    assign hold.beat  = beat_reg;

endmodule

`default_nettype wire

// ----- rtl/core/fpwc_core.sv -----
`default_nettype none

module fpwc_core #(
    parameter int ADDR_BITS = fpwc_pkg::ADDR_BITS_DEFAULT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire fpwc_pkg::fpwc_hold_t hold,
    output logic                      take,
    output logic                      phrase_valid,
    input  wire logic                 phrase_stall,
    output fpwc_pkg::fpwc_out_t       phrase
);
    import fpwc_pkg::*;

    localparam int AW = (ADDR_BITS < FIELD_ADDR_BITS) ? ADDR_BITS : FIELD_ADDR_BITS;
    localparam int IW = AW - OFFSET_BITS;

    logic                   open_reg;
    logic                   open_next;
    logic [PHRASE_BITS-1:0] buf_reg;
    logic [PHRASE_BITS-1:0] buf_next;
    logic [IW-1:0]          idx_reg;
    logic [IW-1:0]          idx_next;
    logic [AW-1:0]          expect_reg;
    logic [AW-1:0]          expect_next;
    logic                   res_valid_reg;
    logic                   res_valid_next;
    fpwc_out_t              res_reg;
    fpwc_out_t              res_next;

    logic                   is_flush;
    logic [AW-1:0]          addr;
    logic [OFFSET_BITS-1:0] offset;
    logic                   contiguous;
    logic [PHRASE_BITS-1:0] base;
    logic [PHRASE_BITS-1:0] inserted;
    logic [IW-1:0]          byte_idx;
    logic                   emit;
    logic                   res_free;

    assign is_flush   = (hold.beat.action == ACT_FLUSH);
    assign addr       = hold.beat.byte_address[AW-1:0];
    assign offset     = addr[OFFSET_BITS-1:0];
    assign contiguous = open_reg && (addr == expect_reg);
    assign base       = contiguous ? buf_reg : BLANK_PHRASE;
    assign byte_idx   = contiguous ? idx_reg : addr[AW-1:OFFSET_BITS];
    assign emit       = is_flush ? open_reg : (offset == LAST_OFFSET);
    assign res_free   = ~res_valid_reg | ~phrase_stall;
    assign take       = hold.valid & (~emit | res_free);

    always_comb
    begin
        inserted = base;
        for (int i = 0; i < PHRASE_BYTES; i++)
        begin
            if (offset == OFFSET_BITS'(i))
            begin
                inserted[i*BYTE_BITS +: BYTE_BITS] = hold.beat.data_byte;
            end
        end
    end

    always_comb
    begin
        open_next      = open_reg;
        buf_next       = buf_reg;
        idx_next       = idx_reg;
        expect_next    = expect_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg & phrase_stall;
        if (take)
        begin
            if (is_flush)
            begin
                if (open_reg)
                begin
                    res_next.phrase_index = INDEX_BITS'(idx_reg);
                    res_next.phrase_data  = buf_reg;
                    res_next.from_flush   = 1'b1;
                    res_valid_next        = 1'b1;
                    open_next             = 1'b0;
                end
            end
            else
            begin
                expect_next = addr + AW'(1);
                idx_next    = byte_idx;
                if (emit)
                begin
                    res_next.phrase_index = INDEX_BITS'(byte_idx);
                    res_next.phrase_data  = inserted;
                    res_next.from_flush   = 1'b0;
                    res_valid_next        = 1'b1;
                    open_next             = 1'b0;
                end
                else
                begin
                    buf_next  = inserted;
                    open_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            open_reg      <= open_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg    <= buf_next;
        idx_reg    <= idx_next;
        expect_reg <= expect_next;
        res_reg    <= res_next;
    end

    assign phrase_valid = res_valid_reg;
    assign phrase       = res_reg;

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 100ps

module tb;

    import fpwc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 8;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      item_valid = 1'b0;
    logic      item_stall;
    fpwc_in_t  item = '0;
    logic      phrase_valid;
    logic      phrase_stall = 1'b0;
    fpwc_out_t phrase;

    fpwc_in_t  pending_items[$];
    fpwc_out_t expected_phrases[$];

    logic [PHRASE_BITS-1:0]     open_bytes = BLANK_PHRASE;
    logic [INDEX_BITS-1:0]      open_index = '0;
    logic [FIELD_ADDR_BITS-1:0] continue_addr = '0;
    logic                       phrase_live = 1'b0;

    int  sender_idle_pct = 0;
    int  stall_pct = 0;
    int  mismatch_count = 0;
    int  cycle_count = 0;
    bit  item_fire = 1'b0;

    flash_phrase_write_combiner DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .phrase_valid (phrase_valid),
        .phrase_stall (phrase_stall),
        .phrase       (phrase)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic close_phrase(input logic flushed);
        fpwc_out_t done;
        done.phrase_index = open_index;
        done.phrase_data  = open_bytes;
        done.from_flush   = flushed;
        expected_phrases.push_back(done);
        phrase_live = 1'b0;
        open_bytes  = BLANK_PHRASE;
    endtask

    task automatic combine_item(input fpwc_in_t it);
        logic [OFFSET_BITS-1:0] offset;
        if (it.action == ACT_FLUSH)
        begin
            if (phrase_live)
                close_phrase(1'b1);
        end
        else
        begin
            if (!phrase_live || it.byte_address != continue_addr)
            begin
                open_bytes  = BLANK_PHRASE;
                open_index  = INDEX_BITS'(it.byte_address >> OFFSET_BITS);
                phrase_live = 1'b1;
            end
            offset = it.byte_address[OFFSET_BITS-1:0];
            open_bytes[offset*BYTE_BITS +: BYTE_BITS] = it.data_byte;
            continue_addr = it.byte_address + 1'b1;
            if (offset == LAST_OFFSET)
                close_phrase(1'b0);
        end
    endtask

    always @(posedge clk)
    begin
        fpwc_out_t want;
        cycle_count++;
        item_fire = rst_n && item_valid && !item_stall;
        if (item_fire)
            combine_item(item);
        if (rst_n && phrase_valid && !phrase_stall)
        begin
            if (expected_phrases.size() == 0)
            begin
                $error("unexpected phrase beat: index %h data %h from_flush %b",
                       phrase.phrase_index, phrase.phrase_data, phrase.from_flush);
                mismatch_count++;
            end
            else
            begin
                want = expected_phrases.pop_front();
                if (phrase.phrase_index !== want.phrase_index)
                begin
                    $error("phrase_index: expected %h, actual %h",
                           want.phrase_index, phrase.phrase_index);
                    mismatch_count++;
                end
                if (phrase.phrase_data !== want.phrase_data)
                begin
                    $error("phrase_data: expected %h, actual %h",
                           want.phrase_data, phrase.phrase_data);
                    mismatch_count++;
                end
                if (phrase.from_flush !== want.from_flush)
                begin
                    $error("from_flush: expected %b, actual %b",
                           want.from_flush, phrase.from_flush);
                    mismatch_count++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            item_valid <= 1'b0;
        else if (!item_valid || item_fire)
        begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
            begin
                item       <= pending_items.pop_front();
                item_valid <= 1'b1;
            end
            else
                item_valid <= 1'b0;
        end
        phrase_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic void queue_byte(input logic [FIELD_ADDR_BITS-1:0] addr,
                                       input logic [BYTE_BITS-1:0] data);
        fpwc_in_t it;
        it.action       = ACT_DATA;
        it.byte_address = addr;
        it.data_byte    = data;
        pending_items.push_back(it);
    endfunction

    function automatic void queue_flush();
        fpwc_in_t it;
        it.action       = ACT_FLUSH;
        it.byte_address = FIELD_ADDR_BITS'($urandom);
        it.data_byte    = BYTE_BITS'($urandom);
        pending_items.push_back(it);
    endfunction

    task automatic queue_traffic(input int count);
        int added;
        int kind;
        int run;
        logic [FIELD_ADDR_BITS-1:0] addr;
        added = 0;
        while (added < count)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 80)
            begin
                addr = FIELD_ADDR_BITS'($urandom);
                case ($urandom_range(0, 7))
                    0: addr[OFFSET_BITS-1:0] = '0;
                    1: addr = {FIELD_ADDR_BITS{1'b1}} - FIELD_ADDR_BITS'($urandom_range(0, 9));
                    2: addr = FIELD_ADDR_BITS'($urandom_range(0, 9));
                    default: ;
                endcase
                run = $urandom_range(1, 12);
                for (int i = 0; i < run; i++)
                begin
                    queue_byte(addr, BYTE_BITS'($urandom));
                    addr = addr + 1'b1;
                end
                added += run;
                if ($urandom_range(0, 1))
                begin
                    queue_flush();
                    added++;
                end
            end
            else if (kind < 90)
            begin
                queue_flush();
                added++;
            end
            else
            begin
                queue_byte(FIELD_ADDR_BITS'($urandom), BYTE_BITS'($urandom));
                added++;
            end
        end
    endtask

    task automatic wait_all_done();
        while (pending_items.size() != 0 || item_valid || expected_phrases.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        queue_flush();
        for (int i = 0; i < 8; i++)
            queue_byte(FIELD_ADDR_BITS'(i), (i == 0) ? 8'h00 : 8'hFF);
        queue_byte(24'hFFFFFD, 8'hA5);
        queue_byte(24'hFFFFFE, 8'h5A);
        queue_byte(24'hFFFFFF, 8'h3C);
        queue_byte(24'h123456, 8'h81);
        queue_flush();
        queue_flush();
        queue_byte(24'h000010, 8'h11);
        queue_byte(24'h000020, 8'h22);
        queue_byte(24'h000021, 8'h33);
        queue_byte(24'h000021, 8'h44);
        queue_flush();
        queue_byte(24'hAAAAAA, 8'h55);
        queue_byte(24'h555555, 8'hAA);
        queue_flush();
        wait_all_done();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin sender_idle_pct = 0;  stall_pct = 0;  end
                1: begin sender_idle_pct = 67; stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  stall_pct = 67; end
                default: begin sender_idle_pct = 19; stall_pct = 19; end
            endcase
            queue_traffic(145);
            wait_all_done();
            queue_traffic(145);
            wait_all_done();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_phrases.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
